// ===== hdl/rvs_pkg.sv =====
// Package for the relative vorticity stencil: word types, geometry and
// configuration constants, sequencer states and multiply-accumulate op codes.
// No dependencies.
`default_nettype none

package rvs_pkg;

  localparam int MaxLon = 1024;
  localparam int MaxLat = 1024;
  localparam int ColW   = $clog2(MaxLon);
  localparam int RowW   = $clog2(MaxLat);
  localparam int AddrW  = ColW + 1;
  localparam int GeomW  = 11;
  localparam int AccW   = 114;

  localparam logic [GeomW-1:0] LonReset    = 11'd360;
  localparam logic [GeomW-1:0] LatReset    = 11'd181;
  localparam logic [31:0]      DphiReset   = 32'd3754936;
  localparam logic [31:0]      DlamReset   = 32'd1877468;
  localparam logic [GeomW-1:0] GeomMin     = 11'd3;
  localparam logic [GeomW-1:0] LonMax      = GeomW'(MaxLon);
  localparam logic [GeomW-1:0] LatMax      = GeomW'(MaxLat);

  typedef enum logic [1:0] {
    CFG_LON_COUNT       = 2'd0,
    CFG_LAT_COUNT       = 2'd1,
    CFG_INV_TWO_DPHI    = 2'd2,
    CFG_INV_TWO_DLAMBDA = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SH_0, SH_16, SH_32, SH_48, SH_64
  } shift_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MULU, ST_WAITU, ST_SATU, ST_DIFF,
    ST_MULA, ST_WAITA, ST_TRUNCA, ST_MULB, ST_WAITB, ST_TRUNCB,
    ST_OUT1, ST_OUT2, ST_WRB
  } state_e;

  typedef struct packed {
    logic        clr;
    logic        vld;
    logic        sub;
    shift_e      sh;
    logic [31:0] a;
    logic [31:0] b;
  } mac_op_t;

  typedef struct packed {
    logic signed [31:0] u_wind;
    logic signed [31:0] v_wind;
    logic [30:0]        cos_lat;
    logic [47:0]        recip_radius_cos;
  } in_word_t;

  typedef struct packed {
    logic signed [47:0] vorticity;
    logic               last_of_run;
  } out_word_t;

  function automatic logic [GeomW-1:0] clamp_geom(input logic [GeomW-1:0] v,
                                                  input logic [GeomW-1:0] hi);
    logic [GeomW-1:0] r;
    if (v < GeomMin) begin
      r = GeomMin;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/relative_vorticity_stencil_top.sv =====
// Top level of the relative vorticity stencil: configuration registers,
// row buffers, sequencer and result register. Depends on rvs_pkg, rvs_mac.
`default_nettype none

// Usage:
// Grid points of one lat-lon slice enter on the in channel (valid/ready) in
// raster order, longitude fastest. Each word carries U, V, cos(lat) and the
// host reciprocal 1/(R*cos). From the second row on, each word yields the
// vorticity of the point one row above on the out channel (valid/ready); the
// first and last rows give zero, and a last-row word gives a second zero
// word for itself; last_of_run is clear only on the first word of that pair.
// From the third row on, an accepted word passes through the U product, the
// difference, the bracket and the row coefficient products before its first
// result is shown; the word is then written back and the block returns to
// idle. It accepts no new word until the last one is written back. The pace
// is set by the single shared 32x32 multiplier, used nine times per word on
// those rows, plus the row buffer read pipeline. A result is held in the
// output register until taken; while the receiver stalls, the block waits
// and accepts nothing. Configuration is written through a plain write port;
// the user must write it only while idle, which the block does not enforce.
// Writing lon_count or lat_count restarts the slice at row 0, column 0.
// Reset returns the registers to their defaults and the slice to its start;
// the row buffers are not cleared, no pass over them is needed.
module relative_vorticity_stencil_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire rvs_pkg::in_word_t   in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output rvs_pkg::out_word_t       out_word_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [31:0]         cfg_wdata_i
);
  import rvs_pkg::*;

  localparam logic [48:0] UPosLim = 49'h0_7FFF_FFFF_FFFF;
  localparam logic [48:0] UNegLim = 49'h0_8000_0000_0000;
  localparam logic [97:0] DPosLim = 98'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [97:0] DNegLim = 98'h8000_0000_0000_0000;
  localparam logic [81:0] RPosLim = 82'h7FFF_FFFF_FFFF;
  localparam logic [81:0] RNegLim = 82'h8000_0000_0000;

  state_e state_q, state_d;
  logic [1:0] step_q, step_d;

  logic [GeomW-1:0] lon_cfg_q, lat_cfg_q;
  logic [31:0]      dphi_q, dlam_q;
  logic [GeomW-1:0] lon, lat, lon_m1, lat_m1;
  logic [RowW-1:0]  row_q;
  logic [ColW-1:0]  col_q;
  logic [47:0]      prev_recip_q;

  in_word_t  in_q;
  out_word_t out_q;

  logic [31:0]      v_cp_q;
  logic [47:0]      ucur_q;
  logic [32:0]      dv_mag_q;
  logic             dv_neg_q;
  logic [48:0]      du_mag_q;
  logic             du_neg_q;
  logic [63:0]      dm_q;
  logic             dneg_q;

  logic [47:0] ucos_mem [0:2*MaxLon-1];
  logic [31:0] v_mem    [0:2*MaxLon-1];
  logic [47:0] ucos_rd_q;
  logic [31:0] v_rd_q;

  logic [GeomW-1:0] c_inc;
  logic [ColW-1:0]  cp, cm;
  logic [AddrW-1:0] v_raddr, u_addr;
  logic             in_acc, geom_bad, last_row, geom_wr;

  mac_op_t         mac_op;
  logic [AccW-1:0] acc;

  logic             u_neg;
  logic [31:0]      u_mag;
  logic [48:0]      ush, umag;
  logic [47:0]      ucur_c;
  logic [32:0]      dv;
  logic [48:0]      du;
  logic             a_neg;
  logic [AccW-1:0]  amag;
  logic [97:0]      ash, dmag;
  logic [81:0]      bsh, rmag;
  logic [47:0]      res_c;

  rvs_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .acc_o  (acc)
  );

  // Geometry and stencil addressing.
  assign lon      = clamp_geom(lon_cfg_q, LonMax);
  assign lat      = clamp_geom(lat_cfg_q, LatMax);
  assign lon_m1   = lon - 11'd1;
  assign lat_m1   = lat - 11'd1;
  assign c_inc    = {1'b0, col_q} + 11'd1;
  assign cp       = (c_inc == lon) ? '0 : c_inc[ColW-1:0];
  assign cm       = (col_q == '0) ? lon_m1[ColW-1:0] : col_q - 10'd1;
  assign v_raddr  = (state_q == ST_MULU) ? {~row_q[0], cp} : {~row_q[0], cm};
  assign u_addr   = {row_q[0], col_q};
  assign in_acc   = in_valid_i && in_ready_o;
  assign geom_bad = ({1'b0, row_q} >= lat) || ({1'b0, col_q} >= lon);
  assign last_row = ({1'b0, row_q} == lat_m1);
  assign geom_wr  = cfg_we_i && ((cfg_idx_i == CFG_LON_COUNT) ||
                                 (cfg_idx_i == CFG_LAT_COUNT));

  // Row buffers: one write port, one read per buffer, registered read data.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRB) begin
      ucos_mem[u_addr] <= ucur_q;
      v_mem[u_addr]    <= in_q.v_wind;
    end
    ucos_rd_q <= ucos_mem[u_addr];
    v_rd_q    <= v_mem[v_raddr];
  end

  // U times cosine, from the magnitude product, truncated and saturated.
  always_comb begin
    u_neg  = in_q.u_wind[31];
    u_mag  = u_neg ? 32'(~in_q.u_wind + 32'd1) : in_q.u_wind;
    ush    = acc[62:14];
    if (u_neg) begin
      umag = (ush > UNegLim) ? UNegLim : ush;
    end else begin
      umag = (ush > UPosLim) ? UPosLim : ush;
    end
    ucur_c = u_neg ? (48'd0 - umag[47:0]) : umag[47:0];
  end

  // Differences and the two truncation steps.
  always_comb begin
    dv    = {v_cp_q[31], v_cp_q} - {v_rd_q[31], v_rd_q};
    du    = {ucur_q[47], ucur_q} - {ucos_rd_q[47], ucos_rd_q};
    a_neg = acc[AccW-1];
    amag  = a_neg ? (~acc + 1'b1) : acc;
    ash   = amag[AccW-1:16];
    if (a_neg) begin
      dmag = (ash > DNegLim) ? DNegLim : ash;
    end else begin
      dmag = (ash > DPosLim) ? DPosLim : ash;
    end
    bsh = acc[113:32];
    if (dneg_q) begin
      rmag = (bsh > RNegLim) ? RNegLim : bsh;
    end else begin
      rmag = (bsh > RPosLim) ? RPosLim : bsh;
    end
    res_c = dneg_q ? (48'd0 - rmag[47:0]) : rmag[47:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    mac_op      = '0;
    mac_op.sh   = SH_0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_MULU;
        end
      end
      ST_MULU: begin
        mac_op.clr = 1'b1;
        mac_op.vld = 1'b1;
        mac_op.a   = u_mag;
        mac_op.b   = {1'b0, in_q.cos_lat};
        state_d    = ST_WAITU;
      end
      ST_WAITU: state_d = ST_SATU;
      ST_SATU: begin
        if (row_q == '0) begin
          state_d = ST_WRB;
        end else if (row_q == 10'd1) begin
          state_d = ST_OUT1;
        end else begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        state_d = ST_MULA;
        step_d  = '0;
      end
      ST_MULA: begin
        // Bracket: dV * inv_two_dlambda * 2^16 minus dUcos * inv_two_dphi.
        mac_op.vld = 1'b1;
        case (step_q)
          2'd0: begin
            mac_op.clr = 1'b1;
            mac_op.a   = dv_mag_q[31:0];
            mac_op.b   = dlam_q;
            mac_op.sh  = SH_16;
            mac_op.sub = dv_neg_q;
          end
          2'd1: begin
            mac_op.a   = {31'd0, dv_mag_q[32]};
            mac_op.b   = dlam_q;
            mac_op.sh  = SH_48;
            mac_op.sub = dv_neg_q;
          end
          2'd2: begin
            mac_op.a   = du_mag_q[31:0];
            mac_op.b   = dphi_q;
            mac_op.sh  = SH_0;
            mac_op.sub = !du_neg_q;
          end
          default: begin
            mac_op.a   = {15'd0, du_mag_q[48:32]};
            mac_op.b   = dphi_q;
            mac_op.sh  = SH_32;
            mac_op.sub = !du_neg_q;
          end
        endcase
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = ST_WAITA;
        end
      end
      ST_WAITA:  state_d = ST_TRUNCA;
      ST_TRUNCA: begin
        state_d = ST_MULB;
        step_d  = '0;
      end
      ST_MULB: begin
        mac_op.vld = 1'b1;
        case (step_q)
          2'd0: begin
            mac_op.clr = 1'b1;
            mac_op.a   = dm_q[31:0];
            mac_op.b   = prev_recip_q[31:0];
            mac_op.sh  = SH_0;
          end
          2'd1: begin
            mac_op.a   = dm_q[31:0];
            mac_op.b   = {16'd0, prev_recip_q[47:32]};
            mac_op.sh  = SH_32;
          end
          2'd2: begin
            mac_op.a   = dm_q[63:32];
            mac_op.b   = prev_recip_q[31:0];
            mac_op.sh  = SH_32;
          end
          default: begin
            mac_op.a   = dm_q[63:32];
            mac_op.b   = {16'd0, prev_recip_q[47:32]};
            mac_op.sh  = SH_64;
          end
        endcase
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = ST_WAITB;
        end
      end
      ST_WAITB:  state_d = ST_TRUNCB;
      ST_TRUNCB: state_d = ST_OUT1;
      ST_OUT1: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = last_row ? ST_OUT2 : ST_WRB;
        end
      end
      ST_OUT2: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_WRB;
        end
      end
      ST_WRB:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          in_q <= in_word_i;
        end
      end
      ST_WAITU: v_cp_q <= v_rd_q;
      ST_SATU: begin
        ucur_q            <= ucur_c;
        out_q.vorticity   <= '0;
        out_q.last_of_run <= !last_row;
      end
      ST_DIFF: begin
        dv_neg_q <= dv[32];
        dv_mag_q <= dv[32] ? (~dv + 33'd1) : dv;
        du_neg_q <= du[48];
        du_mag_q <= du[48] ? (~du + 49'd1) : du;
      end
      ST_TRUNCA: begin
        dneg_q <= a_neg;
        dm_q   <= dmag[63:0];
      end
      ST_TRUNCB: begin
        out_q.vorticity   <= res_c;
        out_q.last_of_run <= !last_row;
      end
      ST_OUT1: begin
        if (out_ready_i && last_row) begin
          out_q.vorticity   <= '0;
          out_q.last_of_run <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_word_o = out_q;

  // Configuration, slice position and row coefficient.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lon_cfg_q    <= LonReset;
      lat_cfg_q    <= LatReset;
      dphi_q       <= DphiReset;
      dlam_q       <= DlamReset;
      row_q        <= '0;
      col_q        <= '0;
      prev_recip_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LON_COUNT:       lon_cfg_q <= cfg_wdata_i[GeomW-1:0];
          CFG_LAT_COUNT:       lat_cfg_q <= cfg_wdata_i[GeomW-1:0];
          CFG_INV_TWO_DPHI:    dphi_q    <= cfg_wdata_i;
          CFG_INV_TWO_DLAMBDA: dlam_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (geom_wr) begin
        row_q <= '0;
        col_q <= '0;
      end else if (in_acc && geom_bad) begin
        row_q <= '0;
        col_q <= '0;
      end else if (state_q == ST_WRB) begin
        if (c_inc == lon) begin
          prev_recip_q <= in_q.recip_radius_cos;
          col_q        <= '0;
          row_q        <= last_row ? '0 : row_q + 10'd1;
        end else begin
          col_q <= c_inc[ColW-1:0];
        end
      end
    end
  end

  a_no_result_first_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (row_q != '0)) else $error("result word on the first row");

  a_second_zero_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT2) |-> last_row) else $error("extra zero word off the last row");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_SATU || $past(state_q) == ST_TRUNCB))
    else $error("result word shown without a finished computation");

endmodule

`default_nettype wire

// ===== hdl/rvs_mac.sv =====
// Shared 32x32 multiply-accumulate unit of the vorticity stencil.
// Registered product, then a shifted add or subtract into a wide accumulator.
// Depends on rvs_pkg.
`default_nettype none

module rvs_mac (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire rvs_pkg::mac_op_t       op_i,
  output logic [rvs_pkg::AccW-1:0]    acc_o
);
  import rvs_pkg::*;

  logic            pv_q;
  logic [63:0]     prod_q;
  logic            psub_q;
  shift_e          psh_q;
  logic [AccW-1:0] acc_q;
  logic [AccW-1:0] ext;
  logic [AccW-1:0] pp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= op_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.vld) begin
      prod_q <= op_i.a * op_i.b;
      psub_q <= op_i.sub;
      psh_q  <= op_i.sh;
    end
  end

  always_comb begin
    ext = AccW'(prod_q);
    case (psh_q)
      SH_0:    pp = ext;
      SH_16:   pp = ext << 16;
      SH_32:   pp = ext << 32;
      SH_48:   pp = ext << 48;
      SH_64:   pp = ext << 64;
      default: pp = ext;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (op_i.clr) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= psub_q ? (acc_q - pp) : (acc_q + pp);
    end
  end

  assign acc_o = acc_q;

  // A clear must never drop a product that is still on its way in.
  a_clr_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i.clr |-> !pv_q) else $error("accumulator cleared with pending product");

endmodule

`default_nettype wire

// ===== test/tb_relative_vorticity_stencil_top.sv =====
// Testbench for the relative vorticity stencil top: directed and random grid
// slices checked against an in-bench fixed-point predictor.
// Depends on rvs_pkg and relative_vorticity_stencil_top.
`default_nettype none

module tb_relative_vorticity_stencil_top;
  import rvs_pkg::*;

  localparam int WatchLimit = 20000;
  localparam int LongHold   = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_word_t out_word_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  relative_vorticity_stencil_top dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state.
  logic [10:0] lon_reg, lat_reg;
  logic [31:0] dphi_reg, dlam_reg;
  logic signed [47:0] ucos_mem [2*MaxLon];
  logic signed [31:0] v_mem [2*MaxLon];
  logic [47:0] row_recip;
  int unsigned row_pos, col_pos;

  out_word_t vort_q[$];
  int errors = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int hold_off = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int quiet = 0;

  // Truncate toward zero by sh bits, then saturate to bits.
  function automatic logic signed [63:0] shrink(input logic signed [127:0] x,
                                                input int sh, input int bits);
    logic signed [127:0] m, lim;
    m = (x < 0) ? -x : x;
    m = m >>> sh;
    if (x < 0) m = -m;
    lim = 128'sd1 <<< (bits - 1);
    if (m > lim - 1) m = lim - 1;
    if (m < -lim) m = -lim;
    return m[63:0];
  endfunction

  function automatic int unsigned clamp3(input logic [10:0] v);
    if (v < 3) return 3;
    if (v > 1024) return 1024;
    return v;
  endfunction

  task automatic expect_word(input out_word_t o);
    vort_q = {vort_q, o};
  endtask

  task automatic predict_point(input in_word_t w);
    int unsigned lon, lat, r, c, cur, prv, cp, cm;
    logic signed [47:0] ucur;
    logic signed [127:0] dv, du, d;
    logic signed [63:0] d64;
    logic signed [47:0] val;
    out_word_t o;
    lon = clamp3(lon_reg);
    lat = clamp3(lat_reg);
    r = row_pos;
    c = col_pos;
    if (r >= lat || c >= lon) begin
      r = 0;
      c = 0;
    end
    cur = (r & 1) * MaxLon;
    prv = ((r + 1) & 1) * MaxLon;
    ucur = 48'(shrink($signed(128'(w.u_wind)) * $signed({97'd0, w.cos_lat}), 14, 48));
    if (r >= 1) begin
      val = '0;
      if (r >= 2) begin
        cp = (c + 1 == lon) ? 0 : c + 1;
        cm = (c == 0) ? lon - 1 : c - 1;
        dv = 128'(v_mem[prv+cp]) - 128'(v_mem[prv+cm]);
        du = 128'(ucur) - 128'(ucos_mem[cur+c]);
        d = (dv * $signed({96'd0, dlam_reg}) <<< 16) - du * $signed({96'd0, dphi_reg});
        d64 = shrink(d, 16, 64);
        val = 48'(shrink(128'(d64) * $signed({80'd0, row_recip}), 32, 48));
      end
      o.vorticity = val;
      o.last_of_run = (r != lat - 1);
      expect_word(o);
      if (r == lat - 1) begin
        o.vorticity = '0;
        o.last_of_run = 1'b1;
        expect_word(o);
      end
    end
    ucos_mem[cur+c] = ucur;
    v_mem[cur+c] = w.v_wind;
    if (c == lon - 1) row_recip = w.recip_radius_cos;
    c++;
    if (c == lon) begin
      c = 0;
      r++;
      if (r == lat) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (vort_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LON_COUNT: begin
        lon_reg = val[10:0];
        row_pos = 0;
        col_pos = 0;
      end
      CFG_LAT_COUNT: begin
        lat_reg = val[10:0];
        row_pos = 0;
        col_pos = 0;
      end
      CFG_INV_TWO_DPHI: dphi_reg = val;
      default: dlam_reg = val;
    endcase
    @(posedge clk_i);
  endtask

  // Valid stays high after an accepted word unless an idle burst follows;
  // the block is busy after each acceptance.
  task automatic send_point(input in_word_t w);
    int gap;
    if (send_idle && $urandom_range(3) == 0) begin
      gap = $urandom_range(16, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_point(w);
  endtask

  function automatic in_word_t rand_point();
    in_word_t w;
    w.u_wind = $urandom;
    w.v_wind = $urandom;
    w.cos_lat = 31'($urandom_range(1073741824));
    w.recip_radius_cos = 48'({$urandom, $urandom});
    case ($urandom_range(7))
      0: w.u_wind = 32'sh7fffffff;
      1: w.v_wind = 32'sh80000000;
      2: w.cos_lat = '1;
      3: w.recip_radius_cos = '1;
      default: ;
    endcase
    return w;
  endfunction

  // Small grid with extreme field values.
  task automatic test_extremes();
    in_word_t w;
    write_reg(CFG_LON_COUNT, 3);
    write_reg(CFG_LAT_COUNT, 3);
    write_reg(CFG_INV_TWO_DPHI, 32'hffffffff);
    write_reg(CFG_INV_TWO_DLAMBDA, 32'hffffffff);
    for (int i = 0; i < 18; i++) begin
      w.u_wind = (i % 2) ? 32'sh80000000 : 32'sh7fffffff;
      w.v_wind = (i % 3 == 0) ? 32'sh7fffffff : 32'sh80000000;
      w.cos_lat = (i % 4 == 0) ? 31'h7fffffff : 31'd1073741824;
      w.recip_radius_cos = (i % 2) ? 48'hffffffffffff : 48'd0;
      send_point(w);
    end
    wait_drained();
  endtask

  // Geometry below the minimum, zero coefficients, and a restart mid-slice.
  task automatic test_clamp_restart();
    write_reg(CFG_LON_COUNT, 0);
    write_reg(CFG_LAT_COUNT, 1);
    write_reg(CFG_INV_TWO_DPHI, 0);
    write_reg(CFG_INV_TWO_DLAMBDA, 0);
    repeat (5) send_point(rand_point());
    wait_drained();
    write_reg(CFG_LAT_COUNT, 4);
    write_reg(CFG_INV_TWO_DPHI, DphiReset);
    write_reg(CFG_INV_TWO_DLAMBDA, DlamReset);
    repeat (7) send_point(rand_point());
    wait_drained();
  endtask

  // Random slices over several geometries.
  task automatic test_random(input int n, input logic [10:0] lon,
                             input logic [10:0] lat);
    write_reg(CFG_LON_COUNT, lon);
    write_reg(CFG_LAT_COUNT, lat);
    write_reg(CFG_INV_TWO_DPHI, $urandom);
    write_reg(CFG_INV_TWO_DLAMBDA, $urandom_range(4000000));
    repeat (n) send_point(rand_point());
    wait_drained();
  endtask

  // Oversized geometry clamps to the maximum width.
  task automatic test_wide();
    write_reg(CFG_LON_COUNT, 11'h7ff);
    write_reg(CFG_LAT_COUNT, 3);
    repeat (1030) send_point(rand_point());
    wait_drained();
  endtask

  // The receiver holds off so the block fills and stalls its input.
  task automatic test_backpressure();
    write_reg(CFG_LON_COUNT, 4);
    write_reg(CFG_LAT_COUNT, 3);
    hold_req++;
    repeat (30) send_point(rand_point());
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_off <= LongHold;
      out_ready_i <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else if (recv_idle && $urandom_range(4) == 0) begin
      hold_off <= $urandom_range(15);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (vort_q.size() == 0) begin
        $display("%0t unexpected word: expected none, actual %h", $time, out_word_o);
        errors++;
      end else begin
        e = vort_q.pop_front();
        if (out_word_o.vorticity !== e.vorticity) begin
          $display("%0t vorticity: expected %h, actual %h", $time, e.vorticity,
                   out_word_o.vorticity);
          errors++;
        end
        if (out_word_o.last_of_run !== e.last_of_run) begin
          $display("%0t last_of_run: expected %b, actual %b", $time, e.last_of_run,
                   out_word_o.last_of_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= WatchLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    lon_reg = LonReset;
    lat_reg = LatReset;
    dphi_reg = DphiReset;
    dlam_reg = DlamReset;
    row_recip = '0;
    row_pos = 0;
    col_pos = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_clamp_restart();
    test_backpressure();
    test_random(210, 3, 3);
    test_random(300, 7, 5);
    test_random(250, 16, 6);
    test_wide();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    test_random(100, 5, 3);
    if (vort_q.size() == 0 && errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/rvs_pkg.sv
hdl/rvs_mac.sv
hdl/relative_vorticity_stencil_top.sv
test/tb_relative_vorticity_stencil_top.sv
